>>> src/slru_pkg.sv
// Package for the set-associative LRU cache lookup.
// Holds payload types, configuration register codes and parameter defaults.
// No dependencies.
`default_nettype none

package slru_pkg;

	localparam int SETS_DEF = 64;
	localparam int WAYS_DEF = 4;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SET_INDEX_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE    = 2'd2;

	localparam logic [4:0] OFFSET_BITS_RST    = 5'd0;
	localparam logic [2:0] SET_INDEX_BITS_RST = 3'd6;
	localparam logic [2:0] WAYS_IN_USE_RST    = 3'd4;

	localparam logic [1:0] RANK_MAX = 2'd3;

	typedef struct packed {
		logic [31:0] address;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [1:0]  way_used;
		logic        replaced_valid;
		logic [31:0] miss_total;
	} rsp_t;

endpackage

`default_nettype wire

>>> src/slru_if.sv
// Valid/ready channel interfaces for the cache lookup.
// Depends on slru_pkg for the payload types.
`default_nettype none

interface slru_req_if
	import slru_pkg::*;
	;
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface slru_rsp_if
	import slru_pkg::*;
	;
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/set_assoc_lru_cache_lookup.sv
// Set-associative cache lookup with LRU replacement, top level.
// Depends on slru_pkg and the channel interfaces in slru_if.sv.
//
// Usage: one address item enters on req; one result item leaves on rsp with
// hit, way_used, replaced_valid and the running miss count. Config registers
// (offset_bits, set_index_bits, ways_in_use) are written on cfg_we/cfg_index/
// cfg_wdata while the block is idle; index 3 is ignored.
// Timing: after an item is accepted the ways of its set are read from the tag
// memory and compared by one comparator, one way per cycle, stopping at the
// first hit or at the last way in use; then the write-back state writes the tag
// (on a miss), valid bits and ranks and registers the result. The next item is
// accepted only after that write-back. The single tag-memory read port and the
// shared comparator make the scan serial.
// Reset: miss count and config registers return to their reset values, and a
// clearing pass zeroes the valid bits one set per cycle; req is not ready
// during it. Config writes are taken at any time.
// Stall: the result sits in an output register; a new item is accepted while
// it waits, but the write-back of that item holds until rsp is free.
`default_nettype none

module set_assoc_lru_cache_lookup
	import slru_pkg::*;
#(
	parameter int SETS = SETS_DEF,
	parameter int WAYS = WAYS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	slru_req_if.sink                   req,
	slru_rsp_if.source                 rsp
);

	localparam int LINES   = SETS * WAYS;
	localparam int SET_AW  = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WIW     = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int LINE_AW = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int MAX_SIB = $clog2(SETS + 1) - 1;

	typedef struct packed {
		logic [WAYS-1:0]       valid;
		logic [WAYS-1:0][1:0]  rank;
	} meta_t;

	typedef enum logic [3:0] {
		ST_CLEAR  = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_SCAN   = 4'b0100,
		ST_UPDATE = 4'b1000
	} state_t;

	meta_t       meta_mem [SETS];
	logic [31:0] tag_mem [LINES];

	state_t            state_q;
	logic [SET_AW-1:0] clr_q;
	logic [4:0]        off_q;
	logic [2:0]        sib_q;
	logic [2:0]        ways_q;
	logic [31:0]       miss_q;

	logic [SET_AW-1:0]  set_q;
	logic [LINE_AW-1:0] base_q;
	logic [31:0]        tag_q;
	logic [WIW-1:0]     nlast_q;
	logic [WIW-1:0]     j_q;
	logic               found_q;
	logic [WIW-1:0]     hitw_q;
	logic               free_q;
	logic [WIW-1:0]     freew_q;
	logic [1:0]         best_q;
	logic [WIW-1:0]     vicw_q;

	meta_t       meta_rd_q;
	logic [31:0] tag_rd_q;

	rsp_t rsp_q;
	logic rsp_valid_q;

	logic               req_fire;
	logic [2:0]         sib_c;
	logic [5:0]         tag_sh;
	logic [31:0]        set_mask;
	logic [SET_AW-1:0]  set_in;
	logic [31:0]        tag_in;
	logic [LINE_AW-1:0] base_in;
	logic [WIW-1:0]     nlast_in;
	logic [LINE_AW-1:0] tag_raddr;

	logic               cur_valid;
	logic [1:0]         cur_rank;
	logic               cur_match;
	logic               scan_last;

	logic               upd_go;
	logic [WIW-1:0]     way_sel;
	logic               was_valid;
	logic [1:0]         old_rank;
	meta_t              meta_new;
	logic               meta_we;
	logic [SET_AW-1:0]  meta_waddr;
	meta_t              meta_wdata;
	logic               tag_we;
	logic [LINE_AW-1:0] tag_waddr;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// address split
	always_comb begin
		sib_c    = (int'(sib_q) > MAX_SIB) ? 3'(MAX_SIB) : sib_q;
		tag_sh   = {1'b0, off_q} + {3'b000, sib_c};
		set_mask = (32'd1 << sib_c) - 32'd1;
		set_in   = SET_AW'((req.data.address >> off_q) & set_mask);
		tag_in   = req.data.address >> tag_sh;
		base_in  = LINE_AW'(set_in) * LINE_AW'(WAYS);
		if (ways_q == 3'd0) begin
			nlast_in = '0;
		end else if (int'(ways_q) > WAYS) begin
			nlast_in = WIW'(WAYS - 1);
		end else begin
			nlast_in = WIW'(ways_q - 3'd1);
		end
	end

	assign tag_raddr = (state_q == ST_SCAN) ? (base_q + LINE_AW'(j_q) + LINE_AW'(1)) : base_in;

	// shared compare on the way currently read
	assign cur_valid = meta_rd_q.valid[j_q];
	assign cur_rank  = meta_rd_q.rank[j_q];
	assign cur_match = cur_valid && (tag_rd_q == tag_q);
	assign scan_last = (j_q == nlast_q);

	// write-back
	always_comb begin
		upd_go = (state_q == ST_UPDATE) && (!rsp_valid_q || rsp.ready);
		priority if (found_q) begin
			way_sel = hitw_q;
		end else if (free_q) begin
			way_sel = freew_q;
		end else begin
			way_sel = vicw_q;
		end
		was_valid = found_q || !free_q;
		old_rank  = meta_rd_q.rank[way_sel];
		meta_new  = meta_rd_q;
		for (int j = 0; j < WAYS; j++) begin
			if (WIW'(j) <= nlast_q && WIW'(j) != way_sel && meta_rd_q.valid[j]
				&& (!was_valid || meta_rd_q.rank[j] < old_rank)
				&& meta_rd_q.rank[j] < RANK_MAX) begin
				meta_new.rank[j] = meta_rd_q.rank[j] + 2'd1;
			end
		end
		meta_new.rank[way_sel]  = 2'd0;
		meta_new.valid[way_sel] = 1'b1;

		meta_we    = (state_q == ST_CLEAR) || upd_go;
		meta_waddr = (state_q == ST_CLEAR) ? clr_q : set_q;
		meta_wdata = (state_q == ST_CLEAR) ? '0 : meta_new;
		tag_we     = upd_go && !found_q;
		tag_waddr  = base_q + LINE_AW'(way_sel);
	end

	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[meta_waddr] <= meta_wdata;
		end
		if (req_fire) begin
			meta_rd_q <= meta_mem[set_in];
		end
		if (tag_we) begin
			tag_mem[tag_waddr] <= tag_q;
		end
		tag_rd_q <= tag_mem[tag_raddr];
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q  <= OFFSET_BITS_RST;
			sib_q  <= SET_INDEX_BITS_RST;
			ways_q <= WAYS_IN_USE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OFFSET_BITS:    off_q  <= cfg_wdata;
				REG_SET_INDEX_BITS: sib_q  <= cfg_wdata[2:0];
				REG_WAYS_IN_USE:    ways_q <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			miss_q      <= '0;
			rsp_valid_q <= 1'b0;
			j_q         <= '0;
			found_q     <= 1'b0;
			free_q      <= 1'b0;
		end else begin
			rsp_valid_q <= upd_go || (rsp_valid_q && !rsp.ready);
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + SET_AW'(1);
					if (clr_q == SET_AW'(SETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						j_q     <= '0;
						found_q <= 1'b0;
						free_q  <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cur_match && !found_q) begin
						found_q <= 1'b1;
					end
					if (!cur_valid && !free_q) begin
						free_q <= 1'b1;
					end
					j_q <= j_q + WIW'(1);
					if (cur_match || scan_last) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (upd_go) begin
						if (!found_q) begin
							miss_q <= miss_q + 32'd1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	// item payload and scan results
	always_ff @(posedge clk) begin
		if (req_fire) begin
			set_q   <= set_in;
			base_q  <= base_in;
			tag_q   <= tag_in;
			nlast_q <= nlast_in;
			best_q  <= 2'd0;
			vicw_q  <= '0;
		end
		if (state_q == ST_SCAN) begin
			if (cur_match && !found_q) begin
				hitw_q <= j_q;
			end
			if (!cur_valid && !free_q) begin
				freew_q <= j_q;
			end
			if (cur_rank > best_q) begin
				best_q <= cur_rank;
				vicw_q <= j_q;
			end
		end
		if (upd_go) begin
			rsp_q.hit            <= found_q;
			rsp_q.way_used       <= 2'(way_sel);
			rsp_q.replaced_valid <= !found_q && !free_q;
			rsp_q.miss_total     <= found_q ? miss_q : (miss_q + 32'd1);
		end
	end

endmodule

`default_nettype wire

>>> src/slru_checker.sv
// Port-level checker for the cache lookup, bound to the top level.
// Depends on slru_pkg and the channel interfaces.
`default_nettype none

module slru_checker
	import slru_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire rsp_t rsp_data
);

	logic        rsp_fire;
	logic [31:0] last_miss_q;

	assign rsp_fire = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_miss_q <= '0;
		end else if (rsp_fire) begin
			last_miss_q <= rsp_data.miss_total;
		end
	end

	// miss count moves by one on a miss only
	a_miss_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_fire |-> (rsp_data.hit ? (rsp_data.miss_total == last_miss_q)
			: (rsp_data.miss_total == last_miss_q + 32'd1)))
		else $error("miss count step wrong");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.hit |-> !rsp_data.replaced_valid)
		else $error("hit reported an eviction");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("item accepted while busy");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("stalled item changed");

endmodule

bind set_assoc_lru_cache_lookup slru_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

`default_nettype wire

>>> test/set_assoc_lru_cache_lookup_test.sv
// Testbench for the set-associative LRU cache lookup: directed and random accesses
// under several register settings, each result checked against an in-bench cache model.
// Depends on slru_pkg, slru_if.sv and set_assoc_lru_cache_lookup.sv.
`timescale 1ns / 1ps

module set_assoc_lru_cache_lookup_test
	import slru_pkg::*;
	;

	localparam int LINES = SETS_DEF * WAYS_DEF;
	localparam int MAX_SIB = $clog2(SETS_DEF);
	localparam int CYCLE_LIMIT = 400000;
	localparam int STALL_PCT = 32;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	slru_req_if req_ch ();
	slru_rsp_if rsp_ch ();

	set_assoc_lru_cache_lookup i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// cache model state
	logic [4:0] cfg_off = OFFSET_BITS_RST;
	logic [2:0] cfg_sib = SET_INDEX_BITS_RST;
	logic [2:0] cfg_ways = WAYS_IN_USE_RST;
	bit line_ok [LINES];
	logic [31:0] line_tag [LINES];
	bit [1:0] line_age [LINES];
	logic [31:0] miss_count = '0;

	rsp_t pending_outcomes[$];
	int mismatches = 0;
	int cycle_count = 0;
	bit calm = 1'b0;

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("set_assoc_lru_cache_lookup_test NOT OK");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < 50)
			$display("%0t: %s: got %0h expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic int unsigned eff_sib();
		return (cfg_sib > MAX_SIB) ? MAX_SIB : cfg_sib;
	endfunction

	function automatic void touch_way(input int unsigned base, input int unsigned nways,
			input int unsigned w, input bit was_valid);
		int unsigned old;
		old = was_valid ? line_age[base + w] : 4;
		for (int j = 0; j < nways; j++)
			if (j != w && line_ok[base + j] && line_age[base + j] < old
					&& line_age[base + j] < RANK_MAX)
				line_age[base + j]++;
		line_age[base + w] = 2'd0;
	endfunction

	function automatic rsp_t lookup_outcome(input logic [31:0] addr);
		int unsigned sib, nways, set_no, base, w, best;
		logic [63:0] wide;
		logic [31:0] tag;
		bit found, free_way;
		rsp_t r;
		sib = eff_sib();
		nways = (cfg_ways == 0) ? 1 : ((cfg_ways > WAYS_DEF) ? WAYS_DEF : cfg_ways);
		wide = 64'(addr);
		set_no = 32'((wide >> cfg_off) & ((64'd1 << sib) - 1));
		tag = 32'(wide >> (cfg_off + sib));
		base = set_no * WAYS_DEF;
		w = 0;
		found = 1'b0;
		r = '0;
		for (int j = 0; j < nways; j++)
			if (!found && line_ok[base + j] && line_tag[base + j] == tag) begin
				w = j;
				found = 1'b1;
			end
		if (found) begin
			r.hit = 1'b1;
			touch_way(base, nways, w, 1'b1);
		end else begin
			miss_count++;
			free_way = 1'b0;
			for (int j = 0; j < nways; j++)
				if (!free_way && !line_ok[base + j]) begin
					w = j;
					free_way = 1'b1;
				end
			if (!free_way) begin
				best = 0;
				w = 0;
				for (int j = 0; j < nways; j++)
					if (line_age[base + j] > best) begin
						best = line_age[base + j];
						w = j;
					end
				r.replaced_valid = 1'b1;
			end
			touch_way(base, nways, w, !free_way);
			line_ok[base + w] = 1'b1;
			line_tag[base + w] = tag;
		end
		r.way_used = w[1:0];
		r.miss_total = miss_count;
		return r;
	endfunction

	// builds an address from tag, set and low bits under the current split
	function automatic logic [31:0] place(input logic [31:0] tag, input int unsigned set_no,
			input logic [31:0] low);
		int unsigned sib;
		logic [63:0] wide;
		sib = eff_sib();
		wide = (64'(tag) << (cfg_off + sib)) | (64'(set_no) << cfg_off)
			| (64'(low) & ((64'd1 << cfg_off) - 1));
		return wide[31:0];
	endfunction

	task automatic send_access(input logic [31:0] addr);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < STALL_PCT) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= addr;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		pending_outcomes.push_back(lookup_outcome(addr));
	endtask

	task automatic drain_results();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_outcomes.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_OFFSET_BITS: cfg_off = val[4:0];
			REG_SET_INDEX_BITS: cfg_sib = val[2:0];
			REG_WAYS_IN_USE: cfg_ways = val[2:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_setting(input logic [4:0] off, input logic [4:0] sibw,
			input logic [4:0] waysw);
		drain_results();
		write_reg(REG_OFFSET_BITS, off);
		write_reg(REG_SET_INDEX_BITS, sibw);
		write_reg(REG_WAYS_IN_USE, waysw);
	endtask

	// reset setting: extremes of the address, fills and LRU evictions in one set
	task automatic test_default_lookup();
		send_access(32'h0000_0000);
		send_access(32'h0000_0000);
		send_access(32'hFFFF_FFFF);
		send_access(32'hFFFF_FFFF);
		for (int t = 1; t <= 5; t++)
			send_access(place(t, 1, 0));
		send_access(place(1, 1, 0));
		send_access(place(3, 1, 0));
	endtask

	// offset and index cover the whole address, so the tag is zero;
	// oversized index and zero ways, plus a write to the unused index
	task automatic test_wide_split();
		apply_setting(5'd31, 5'h1F, 5'h08);
		write_reg(REG_UNUSED, 5'h1F);
		send_access(32'h8000_0000);
		send_access(32'h7FFF_FFFF);
		send_access(32'hFFFF_FFFF);
		send_access(32'h0000_0000);
	endtask

	// shrinking the ways can leave the same tag in two ways of a set
	task automatic test_equal_tags();
		apply_setting(5'd0, 5'd0, 5'd4);
		send_access(32'h0000_00A1);
		send_access(32'h0000_00A2);
		send_access(32'h0000_00A3);
		apply_setting(5'd0, 5'd0, 5'd1);
		send_access(32'h0000_00A3);
		apply_setting(5'd0, 5'd0, 5'd4);
		send_access(32'h0000_00A3);
		send_access(32'h0000_00A1);
	endtask

	// mostly a few tags over a few sets so lines are reused and evicted
	task automatic test_random_setting(input logic [4:0] off, input logic [4:0] sibw,
			input logic [4:0] waysw, input int count, input bit steady);
		int unsigned set_no, top_set;
		logic [31:0] tag;
		apply_setting(off, sibw, waysw);
		calm = steady;
		top_set = (1 << eff_sib()) - 1;
		for (int n = 0; n < count; n++) begin
			set_no = ($urandom_range(0, 9) == 0) ? $urandom_range(0, top_set)
				: $urandom_range(0, (top_set < 3) ? top_set : 3);
			tag = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 5);
			if ($urandom_range(0, 99) < 12)
				send_access($urandom);
			else
				send_access(place(tag, set_no, $urandom));
		end
		calm = 1'b0;
	endtask

	always @(negedge clk)
		rsp_ch.ready <= calm || ($urandom_range(0, 99) >= STALL_PCT);

	always @(posedge clk) begin : check_results
		rsp_t want;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_outcomes.size() == 0) begin
				report_mismatch("result with nothing pending", rsp_ch.data.miss_total, '0);
			end else begin
				want = pending_outcomes.pop_front();
				if (rsp_ch.data.hit !== want.hit)
					report_mismatch("hit", rsp_ch.data.hit, want.hit);
				if (rsp_ch.data.way_used !== want.way_used)
					report_mismatch("way_used", rsp_ch.data.way_used, want.way_used);
				if (rsp_ch.data.replaced_valid !== want.replaced_valid)
					report_mismatch("replaced_valid", rsp_ch.data.replaced_valid,
						want.replaced_valid);
				if (rsp_ch.data.miss_total !== want.miss_total)
					report_mismatch("miss_total", rsp_ch.data.miss_total, want.miss_total);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_default_lookup();
		test_wide_split();
		test_equal_tags();
		test_random_setting(5'd0, 5'd6, 5'd4, 100, 1'b0);
		test_random_setting(5'd4, 5'd2, 5'd2, 100, 1'b0);
		test_random_setting(5'd2, 5'd0, 5'd1, 100, 1'b0);
		test_random_setting(5'd31, 5'h1F, 5'h1F, 100, 1'b0);
		test_random_setting(5'd28, 5'd3, 5'd3, 100, 1'b0);
		test_random_setting(5'd6, 5'd1, 5'h08, 100, 1'b0);
		test_random_setting(5'd3, 5'd4, 5'd5, 100, 1'b0);
		test_random_setting(5'd0, 5'd6, 5'd4, 100, 1'b1);

		drain_results();
		repeat (12) @(negedge clk);
		if (pending_outcomes.size() != 0)
			report_mismatch("results missing", pending_outcomes.size(), '0);
		if (mismatches == 0)
			$display("set_assoc_lru_cache_lookup_test OK");
		else
			$display("set_assoc_lru_cache_lookup_test NOT OK");
		$finish;
	end

endmodule
